// ===== src/faprot_pkg.sv =====
// ----------------------------------------------------------------------------
// faprot_pkg: shared types, constants and tables
// Defaults, register indexes, the reciprocal table of the Taylor divisors
// and the state encoding of the sine/cosine sequencer.
// ----------------------------------------------------------------------------
package faprot_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int NUM_ANGLES      = 4;
  localparam int CFG_IDX_W       = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_Z  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_Z = 3'd3;

  // Pi in Q2.30, so that (phase * PI_Q30) >> 31 gives radians.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Fraction bits of the stored sine and cosine.
  function automatic int trig_frac(input int cw);
    int f;
    f = 62 - cw;
    return (f < 30) ? f : 30;
  endfunction

  // Division of a 32-bit numerator by a Horner divisor 2^pre * d, d odd:
  // the numerator is shifted right by pre, then multiplied by
  // ceil(2^(31+post) / d) and shifted right by 31 + post. With 2^post >= d
  // this gives the exact floor quotient for any 31-bit shifted numerator.
  typedef struct packed {
    logic [1:0]  pre;
    logic [31:0] magic;
    logic [2:0]  post;
  } recip_t;

  function automatic recip_t make_recip(input int dd, input int pre, input int l);
    recip_t r;
    r.pre   = 2'(pre);
    r.post  = 3'(l);
    r.magic = 32'(((64'd1 << (31 + l)) + 64'(dd) - 64'd1) / 64'(dd));
    return r;
  endfunction

  // Indexed by {odd, k}: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
  localparam recip_t HORNER_RECIP [16] = '{
    make_recip(1, 0, 0),    // unused
    make_recip(1, 1, 0),    // 2
    make_recip(3, 2, 2),    // 12
    make_recip(15, 1, 4),   // 30
    make_recip(7, 3, 3),    // 56
    make_recip(45, 1, 6),   // 90
    make_recip(33, 2, 6),   // 132
    make_recip(91, 1, 7),   // 182
    make_recip(1, 0, 0),    // unused
    make_recip(3, 1, 2),    // 6
    make_recip(5, 2, 3),    // 20
    make_recip(21, 1, 5),   // 42
    make_recip(9, 3, 4),    // 72
    make_recip(55, 1, 6),   // 110
    make_recip(39, 2, 6),   // 156
    make_recip(105, 1, 7)   // 210
  };

  typedef enum logic [3:0] {
    TRIG_IDLE,
    TRIG_MUL_T,
    TRIG_GET_T,
    TRIG_MUL_S2,
    TRIG_GET_S2,
    TRIG_MUL_H,
    TRIG_DIV_LOAD,
    TRIG_DIV,
    TRIG_ACC,
    TRIG_MUL_SN,
    TRIG_GET_SN,
    TRIG_STORE
  } trig_state_e;

endpackage

// ===== src/faprot_trig.sv =====
// ----------------------------------------------------------------------------
// faprot_trig: sine/cosine sequencer
// Derives the sine and cosine of a written angle with one shared multiplier,
// dividing by reciprocal multiplication, and holds the four derived pairs.
// ----------------------------------------------------------------------------
module faprot_trig import faprot_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int TW = trig_frac(COORD_WIDTH) + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [1:0]             wr_idx_i,
  input  logic [ANGLE_WIDTH-1:0] wr_angle_i,
  output logic                   busy_o,
  output logic signed [TW-1:0]   sin_o [NUM_ANGLES],
  output logic signed [TW-1:0]   cos_o [NUM_ANGLES]
);

  localparam int TF    = trig_frac(COORD_WIDTH);
  localparam int RND_N = 30 - TF;
  localparam logic [31:0] RND_ADD = (RND_N == 0) ? 32'd0 : (32'd1 << (RND_N - 1));
  localparam logic [30:0] ONE = 31'h4000_0000;
  localparam logic signed [TW-1:0] COS_RST = TW'(1) << TF;

  trig_state_e state_q, state_d;

  logic [2:0]  k_q, k_d;
  logic        odd_q, odd_d;

  logic [1:0]  idx_q, quad_q;
  logic [29:0] r_q;
  logic [30:0] t_q;
  logic [31:0] s2_q;
  logic [30:0] acc_q, sn_q;
  logic [63:0] prod_q;
  logic [31:0] num_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] phase;
  recip_t      rcp;
  logic [63:0] quo;

  // Rounds a Q2.30 magnitude to TF fraction bits and applies the sign.
  function automatic logic signed [TW-1:0] to_frac(input logic [30:0] mag, input logic neg);
    logic [31:0] sum;
    logic [31:0] m;
    sum = {1'b0, mag} + RND_ADD;
    m   = sum >> RND_N;
    return neg ? -$signed(m[TW-1:0]) : $signed(m[TW-1:0]);
  endfunction

  assign phase = {wr_angle_i, {(32 - ANGLE_WIDTH){1'b0}}};
  assign rcp   = HORNER_RECIP[{odd_q, k_q}];
  assign quo   = prod_q >> (6'd31 + 6'(rcp.post));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      TRIG_IDLE:     if (wr_en_i) state_d = TRIG_MUL_T;
      TRIG_MUL_T:    state_d = TRIG_GET_T;
      TRIG_GET_T:    state_d = TRIG_MUL_S2;
      TRIG_MUL_S2:   state_d = TRIG_GET_S2;
      TRIG_GET_S2:   state_d = TRIG_MUL_H;
      TRIG_MUL_H:    state_d = TRIG_DIV_LOAD;
      TRIG_DIV_LOAD: state_d = TRIG_DIV;
      TRIG_DIV:      state_d = TRIG_ACC;
      TRIG_ACC: begin
        if (k_q != 3'd1) state_d = TRIG_MUL_H;
        else if (odd_q)  state_d = TRIG_MUL_SN;
        else             state_d = TRIG_STORE;
      end
      TRIG_MUL_SN:   state_d = TRIG_GET_SN;
      TRIG_GET_SN:   state_d = TRIG_MUL_H;
      TRIG_STORE:    state_d = TRIG_IDLE;
      default:       state_d = TRIG_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy flag, multiplier operands, loop counters.
  always_comb begin
    busy_o = (state_q != TRIG_IDLE);
    mul_a  = '0;
    mul_b  = '0;
    k_d    = k_q;
    odd_d  = odd_q;
    case (state_q)
      TRIG_MUL_T: begin
        mul_a = {2'b00, r_q};
        mul_b = PI_Q30;
      end
      TRIG_MUL_S2: begin
        mul_a = {1'b0, t_q};
        mul_b = {1'b0, t_q};
      end
      TRIG_MUL_H: begin
        mul_a = s2_q;
        mul_b = {1'b0, acc_q};
      end
      TRIG_DIV: begin
        mul_a = num_q;
        mul_b = rcp.magic;
      end
      TRIG_MUL_SN: begin
        mul_a = {1'b0, t_q};
        mul_b = {1'b0, acc_q};
      end
      TRIG_GET_S2: begin
        k_d   = 3'd7;
        odd_d = 1'b1;
      end
      TRIG_GET_SN: begin
        k_d   = 3'd7;
        odd_d = 1'b0;
      end
      TRIG_ACC:      if (k_q != 3'd1) k_d = k_q - 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_IDLE;
      k_q     <= 3'd7;
      odd_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      odd_q   <= odd_d;
    end
  end

  // Working registers of the derivation.
  always_ff @(posedge clk_i) begin
    case (state_q)
      TRIG_IDLE: begin
        if (wr_en_i) begin
          idx_q  <= wr_idx_i;
          quad_q <= phase[31:30];
          r_q    <= phase[29:0];
        end
      end
      TRIG_MUL_T, TRIG_MUL_S2, TRIG_MUL_H, TRIG_DIV, TRIG_MUL_SN: prod_q <= mul_a * mul_b;
      TRIG_GET_T:  t_q <= prod_q[61:31];
      TRIG_GET_S2: begin
        s2_q  <= prod_q[61:30];
        acc_q <= ONE;
      end
      // The power-of-two part of the divisor is a plain shift.
      TRIG_DIV_LOAD: num_q <= prod_q[61:30] >> rcp.pre;
      TRIG_ACC: acc_q <= (quo >= 64'(ONE)) ? '0 : ONE - quo[30:0];
      TRIG_GET_SN: begin
        sn_q  <= (prod_q[60:30] > ONE) ? ONE : prod_q[60:30];
        acc_q <= ONE;
      end
      default: ;
    endcase
  end

  // Derived pairs; at reset every angle is zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ANGLES; i++) begin
        sin_o[i] <= '0;
        cos_o[i] <= COS_RST;
      end
    end else if (state_q == TRIG_STORE) begin
      case (quad_q)
        2'd0: begin
          sin_o[idx_q] <= to_frac(sn_q, 1'b0);
          cos_o[idx_q] <= to_frac(acc_q, 1'b0);
        end
        2'd1: begin
          sin_o[idx_q] <= to_frac(acc_q, 1'b0);
          cos_o[idx_q] <= to_frac(sn_q, 1'b1);
        end
        2'd2: begin
          sin_o[idx_q] <= to_frac(sn_q, 1'b1);
          cos_o[idx_q] <= to_frac(acc_q, 1'b1);
        end
        default: begin
          sin_o[idx_q] <= to_frac(acc_q, 1'b1);
          cos_o[idx_q] <= to_frac(sn_q, 1'b0);
        end
      endcase
    end
  end

endmodule

// ===== src/faprot_rot.sv =====
// ----------------------------------------------------------------------------
// faprot_rot: one planar rotation stage pair
// Multiplies in the first register stage, then sums, rounds and saturates
// in the second. The third coordinate travels alongside.
// ----------------------------------------------------------------------------
module faprot_rot import faprot_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter bit NEG_SIN     = 1'b0,
  localparam int VW = COORD_WIDTH + 1,
  localparam int TW = trig_frac(COORD_WIDTH) + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [VW-1:0] u_i,
  input  logic signed [VW-1:0] v_i,
  input  logic signed [VW-1:0] w_i,
  input  logic signed [TW-1:0] cos_i,
  input  logic signed [TW-1:0] sin_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [VW-1:0] u_o,
  output logic signed [VW-1:0] v_o,
  output logic signed [VW-1:0] w_o
);

  localparam int TF = trig_frac(COORD_WIDTH);
  localparam int PW = VW + TW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] RND = SW'(1) << (TF - 1);
  localparam logic signed [SW-1:0] LIM = {{(SW - COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

  logic                 mul_valid_q, out_valid_q;
  logic                 mul_ready, out_ready;
  logic signed [TW-1:0] sin_eff;
  logic signed [PW-1:0] cu_q, sv_q, su_q, cv_q;
  logic signed [VW-1:0] w1_q, u_q, v_q, w_q;
  logic signed [SW-1:0] sum_u, sum_v;

  function automatic logic signed [VW-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    sh = (s + RND) >>> TF;
    if (sh > LIM) return LIM[VW-1:0];
    if (sh < -LIM) return -LIM[VW-1:0];
    return sh[VW-1:0];
  endfunction

  assign sin_eff    = NEG_SIN ? -sin_i : sin_i;
  assign out_ready  = !out_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || out_ready;
  assign in_ready_o = mul_ready;

  assign sum_u = SW'(cu_q) - SW'(sv_q);
  assign sum_v = SW'(su_q) + SW'(cv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_ready) mul_valid_q <= in_valid_i;
      if (out_ready) out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      cu_q <= cos_i * u_i;
      sv_q <= sin_eff * v_i;
      su_q <= sin_eff * u_i;
      cv_q <= cos_i * v_i;
      w1_q <= w_i;
    end
    if (out_ready && mul_valid_q) begin
      u_q <= rnd_sat(sum_u);
      v_q <= rnd_sat(sum_v);
      w_q <= w1_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign u_o = u_q;
  assign v_o = v_q;
  assign w_o = w_q;

endmodule

// ===== src/four_angle_point_rotation_top.sv =====
// ----------------------------------------------------------------------------
// four_angle_point_rotation_top: 3D point rotation by four angles
// Rotates each point about Y by a, about Z by -b, about Z by d and about
// Y by -c, in signed fixed point, with saturated results.
// ----------------------------------------------------------------------------
// Usage:
// Points enter on the s_axis channel, one word per point, and leave on the
// m_axis channel in the same order. Each rotation takes two register stages
// (products, then sum, round and saturate). One point is taken every cycle
// while the sequencer is idle and no stage is held; each stage has its own
// valid bit and collapses bubbles, so a point still enters while a finished
// result waits for the receiver. When the receiver stalls, words stay in
// their stages and tready drops only once the stages ahead are full.
// The angles are written on the cfg channel while no point is in flight.
// Each write to one of the four angles starts the sine/cosine sequencer,
// which shares one 32x32 multiplier over fourteen Taylor steps (multiply,
// load, divide, accumulate), dividing by reciprocal multiplication; while
// it runs, cfg_ready_o and s_axis_tready are low. Writes to indexes beyond
// the four angles are taken and ignored.
// Reset clears all stages and sets every angle to zero (identity rotation),
// with no sequencer pass needed.
// ----------------------------------------------------------------------------
module four_angle_point_rotation_top import faprot_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: point_x, point_y, point_z, zero fill.
  input  logic [DATA_W-1:0]      s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: rotated_x, rotated_y, rotated_z, zero fill.
  output logic [DATA_W-1:0]      m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ANGLE_WIDTH-1:0] cfg_data_i
);

  localparam int CW = COORD_WIDTH;
  localparam int VW = CW + 1;
  localparam int TW = trig_frac(CW) + 2;
  localparam logic signed [VW-1:0] OUT_MAX = {2'b00, {(CW - 1){1'b1}}};
  localparam logic signed [VW-1:0] OUT_MIN = {2'b11, {(CW - 1){1'b0}}};

  logic                 trig_busy, trig_wr;
  logic signed [TW-1:0] sin_w [NUM_ANGLES];
  logic signed [TW-1:0] cos_w [NUM_ANGLES];

  // Stage boundaries: index 0 is the input, index 4 the last rotation.
  logic                 valid_w [5];
  logic                 ready_w [5];
  logic signed [VW-1:0] x_w [5];
  logic signed [VW-1:0] y_w [5];
  logic signed [VW-1:0] z_w [5];

  function automatic logic [CW-1:0] sat_out(input logic signed [VW-1:0] v);
    if (v > OUT_MAX) return OUT_MAX[CW-1:0];
    if (v < OUT_MIN) return OUT_MIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  // A write to one of the four angles starts the sequencer.
  assign cfg_ready_o = !trig_busy;
  assign trig_wr     = cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_ANGLES));

  faprot_trig #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (trig_wr),
    .wr_idx_i   (cfg_index_i[1:0]),
    .wr_angle_i (cfg_data_i),
    .busy_o     (trig_busy),
    .sin_o      (sin_w),
    .cos_o      (cos_w)
  );

  // Inputs are widened by one bit; intermediates saturate to that range.
  assign valid_w[0]    = s_axis_tvalid && !trig_busy;
  assign s_axis_tready = ready_w[0] && !trig_busy;
  assign x_w[0] = VW'($signed(s_axis_tdata[CW-1:0]));
  assign y_w[0] = VW'($signed(s_axis_tdata[2*CW-1:CW]));
  assign z_w[0] = VW'($signed(s_axis_tdata[3*CW-1:2*CW]));

  // About Y by a: the pair is (z, x).
  faprot_rot #(.COORD_WIDTH(CW), .NEG_SIN(1'b0)) u_rot_ya (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(valid_w[0]), .in_ready_o(ready_w[0]),
    .u_i(z_w[0]), .v_i(x_w[0]), .w_i(y_w[0]),
    .cos_i(cos_w[REG_FIRST_Y[1:0]]), .sin_i(sin_w[REG_FIRST_Y[1:0]]),
    .out_valid_o(valid_w[1]), .out_ready_i(ready_w[1]),
    .u_o(z_w[1]), .v_o(x_w[1]), .w_o(y_w[1])
  );

  // About Z by minus b: the pair is (x, y).
  faprot_rot #(.COORD_WIDTH(CW), .NEG_SIN(1'b1)) u_rot_zb (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(valid_w[1]), .in_ready_o(ready_w[1]),
    .u_i(x_w[1]), .v_i(y_w[1]), .w_i(z_w[1]),
    .cos_i(cos_w[REG_FIRST_Z[1:0]]), .sin_i(sin_w[REG_FIRST_Z[1:0]]),
    .out_valid_o(valid_w[2]), .out_ready_i(ready_w[2]),
    .u_o(x_w[2]), .v_o(y_w[2]), .w_o(z_w[2])
  );

  // About Z by d.
  faprot_rot #(.COORD_WIDTH(CW), .NEG_SIN(1'b0)) u_rot_zd (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(valid_w[2]), .in_ready_o(ready_w[2]),
    .u_i(x_w[2]), .v_i(y_w[2]), .w_i(z_w[2]),
    .cos_i(cos_w[REG_SECOND_Z[1:0]]), .sin_i(sin_w[REG_SECOND_Z[1:0]]),
    .out_valid_o(valid_w[3]), .out_ready_i(ready_w[3]),
    .u_o(x_w[3]), .v_o(y_w[3]), .w_o(z_w[3])
  );

  // About Y by minus c.
  faprot_rot #(.COORD_WIDTH(CW), .NEG_SIN(1'b1)) u_rot_yc (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(valid_w[3]), .in_ready_o(ready_w[3]),
    .u_i(z_w[3]), .v_i(x_w[3]), .w_i(y_w[3]),
    .cos_i(cos_w[REG_SECOND_Y[1:0]]), .sin_i(sin_w[REG_SECOND_Y[1:0]]),
    .out_valid_o(valid_w[4]), .out_ready_i(ready_w[4]),
    .u_o(z_w[4]), .v_o(x_w[4]), .w_o(y_w[4])
  );

  // The last stage register is the output register; the clamp to the
  // coordinate range follows it.
  assign ready_w[4]    = m_axis_tready;
  assign m_axis_tvalid = valid_w[4];
  assign m_axis_tdata  = DATA_W'({sat_out(z_w[4]), sat_out(y_w[4]), sat_out(x_w[4])});

  // No point is taken while the sine/cosine pairs are being rewritten.
  a_no_point_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !trig_busy)
    else $error("point accepted during angle derivation");

  // A write to a valid angle index starts the sequencer.
  a_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_wr |=> trig_busy)
    else $error("angle write did not start the sequencer");

  // The sequencer only becomes busy from a configuration write.
  a_busy_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(trig_busy) |-> $past(trig_wr))
    else $error("sequencer started without a write");

endmodule

// ===== verif/four_angle_point_rotation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_angle_point_rotation_top_tb: self-checking bench for the point rotator
// Streams 3D points through the block under several angle settings and
// compares every rotated word against a bit-accurate fixed-point predictor or a typed expectation.
// ----------------------------------------------------------------------------
module four_angle_point_rotation_top_tb;
  import faprot_pkg::*;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int DW = 96;
  localparam int NUM_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 175;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint SAT_LIM = (64'sd1 <<< CW) - 1;
  // Indexes past the four angles; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } point_t;

  typedef struct {
    logic [CW-1:0] x, y, z;
    bit            typed;   // expected word given in the row itself
    logic [CW-1:0] ex, ey, ez;
  } point_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DW-1:0]     s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DW-1:0]     m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [AW-1:0]     cfg_data_i;

  four_angle_point_rotation_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor state: sine and cosine of each angle register, Q2.30.
  longint angle_sin[NUM_ANGLES];
  longint angle_cos[NUM_ANGLES];

  point_t rotated_q[$];
  int     mismatch_count = 0;
  int     points_sent = 0;
  longint cycle_count = 0;

  point_row_t point_table[] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
    '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1,
      32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1,
      32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1,
      32'h0000_0000, 32'h0000_0000, 32'h0001_0000},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0, '0, '0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, '0, '0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0, '0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0, '0, '0},
    '{32'hFFFF_0000, 32'h0000_FFFF, 32'h00FF_FF00, 0, '0, '0, '0}
  };

  // Angle settings per phase, in register order: a, b, c, d. Phase 0 keeps
  // the reset angles; the last phases draw theirs at random.
  logic [AW-1:0] phase_angles [4][NUM_ANGLES] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h4000, 16'h8000, 16'h7FFF, 16'hFFFF},
    '{16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
    '{16'hC000, 16'h2000, 16'hE000, 16'h0000}
  };

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Truncated Taylor series by Horner's rule; odd selects the sine divisors.
  function automatic longint unsigned taylor_series(longint unsigned s2, int odd);
    longint unsigned acc, div, sub;
    acc = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      div = longint'((2 * k - 1 + odd) * (2 * k + odd));
      sub = ((s2 * acc) >> 30) / div;
      acc = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
    end
    return acc;
  endfunction

  // Recomputes the sine and cosine of one angle register.
  function automatic void load_angle(int idx, logic [AW-1:0] ang);
    logic [31:0]     phase;
    longint unsigned rem, t, s2, sn, cs;
    phase = {ang, 16'h0000};
    rem = longint'(phase[29:0]);
    t = (rem * longint'(PI_Q30)) >> 31;
    s2 = (t * t) >> 30;
    sn = (t * taylor_series(s2, 1)) >> 30;
    cs = taylor_series(s2, 0);
    if (sn > Q30_ONE) sn = Q30_ONE;
    // The quadrant folds the in-quadrant pair onto the full circle.
    case (phase[31:30])
      2'd0: begin angle_sin[idx] =  sn; angle_cos[idx] =  cs; end
      2'd1: begin angle_sin[idx] =  cs; angle_cos[idx] = -sn; end
      2'd2: begin angle_sin[idx] = -sn; angle_cos[idx] = -cs; end
      default: begin angle_sin[idx] = -cs; angle_cos[idx] = sn; end
    endcase
  endfunction

  function automatic longint round_clamp(longint sum);
    longint v;
    v = (sum + (64'sd1 <<< 29)) >>> 30;
    if (v > SAT_LIM) v = SAT_LIM;
    if (v < -SAT_LIM) v = -SAT_LIM;
    return v;
  endfunction

  function automatic void plane_turn(inout longint u, inout longint v,
                                     input longint c, input longint s);
    longint a, b;
    a = u;
    b = v;
    u = round_clamp(c * a - s * b);
    v = round_clamp(s * a + c * b);
  endfunction

  function automatic logic [CW-1:0] clamp_coord(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[CW-1:0];
  endfunction

  function automatic point_t rotate_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                          logic [CW-1:0] pz);
    longint x, y, z;
    point_t r;
    x = longint'(signed'(px));
    y = longint'(signed'(py));
    z = longint'(signed'(pz));
    plane_turn(z, x, angle_cos[REG_FIRST_Y],   angle_sin[REG_FIRST_Y]);
    plane_turn(x, y, angle_cos[REG_FIRST_Z],  -angle_sin[REG_FIRST_Z]);
    plane_turn(x, y, angle_cos[REG_SECOND_Z],  angle_sin[REG_SECOND_Z]);
    plane_turn(z, x, angle_cos[REG_SECOND_Y], -angle_sin[REG_SECOND_Y]);
    r.x = clamp_coord(x);
    r.y = clamp_coord(y);
    r.z = clamp_coord(z);
    return r;
  endfunction

  // Mostly ordinary coordinates, with extremes and full-range noise mixed in.
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
      default: return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("four_angle_point_rotation_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one point and holds it until the block takes the word; tvalid is
  // left high so that back-to-back points run without a bubble.
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py,
                            logic [CW-1:0] pz, bit typed, point_t typed_word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    rotated_q.push_back(typed ? typed_word : rotate_point(px, py, pz));
    points_sent++;
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Each write drops cfg_valid_i once the block has taken it and leaves the cfg channel idle before returning.
  task automatic write_angle(logic [CFG_IDX_W-1:0] idx, logic [AW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_ANGLES) load_angle(idx, value);
    @(posedge clk_i);
  endtask

  // Lets every point in flight come out before the angles may change.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    point_t typed_word;
    logic [AW-1:0] ang;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_FIRST_Y;
    cfg_data_i    = '0;
    for (int i = 0; i < NUM_ANGLES; i++) load_angle(i, '0);

    @(posedge rst_ni);
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        for (int i = 0; i < NUM_ANGLES; i++) begin
          ang = (ph < 4) ? phase_angles[ph][i] : 16'($urandom);
          write_angle(CFG_IDX_W'(i), ang);
        end
        // Writes to the spare indexes must leave the angles untouched.
        if (ph == 1 || ph == 3)
          write_angle(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      16'($urandom));
      end

      // Directed rows: under the reset angles the rotation is the identity,
      // so the typed expectation is the point itself.
      if (ph < 2) begin
        foreach (point_table[i]) begin
          typed_word = '{z: point_table[i].ez, y: point_table[i].ey,
                         x: point_table[i].ex};
          send_point(point_table[i].x, point_table[i].y, point_table[i].z,
                     ph == 0 && point_table[i].typed, typed_word);
        end
      end

      // Random points in bursts; some bursts run with no gap after them.
      for (int n = 0; n < RANDOM_PER_PHASE; n += burst) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst; k++)
          send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, '0);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("four_angle_point_rotation_top verification clean");
    end else begin
      $display("four_angle_point_rotation_top verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // The stall pattern is redrawn as the run goes on: always ready, random, or
  // mostly stalled. Once, after a few hundred points, the receiver holds off
  // for a long stretch so that the stages fill up and tready drops.
  initial begin
    int pattern;
    bit long_hold_done;
    m_axis_tready = 1'b0;
    pattern = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && points_sent >= 400) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (cycle_count % 64 == 0) pattern = $urandom_range(0, 3);
      case (pattern)
        0, 1: m_axis_tready <= 1'b1;
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each word taken from the block is checked against the oldest expectation.
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        mismatch_count++;
      end else begin
        want = rotated_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: rotated_x expected %h actual %h", $time, want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: rotated_y expected %h actual %h", $time, want.y, got.y);
          mismatch_count++;
        end
        if (got.z !== want.z) begin
          $display("%0t: rotated_z expected %h actual %h", $time, want.z, got.z);
          mismatch_count++;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
src/faprot_pkg.sv
src/faprot_trig.sv
src/faprot_rot.sv
src/four_angle_point_rotation_top.sv
verif/four_angle_point_rotation_top_tb.sv
